### design/balloc_pkg.sv
// Shared types and codes for the block allocator.
// Depends on nothing; every other design file but balloc_ram imports it.
package balloc_pkg;

  localparam int MAX_BLOCKS = 4096;

  localparam int CMD_W = 3;
  localparam int BLK_W = 12;
  localparam int RES_W = 13;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOCATE      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK          = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE          = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MARK_USED     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MARK_MODIFIED = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ADD_REF       = 3'd5;

  localparam logic [ST_W-1:0] ST_OK           = 2'd0;
  localparam logic [ST_W-1:0] ST_ALREADY_FREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE        = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL         = 2'd3;

  localparam logic [31:0] UC_MAX = 32'hFFFF_FFFF;

  // front-end classification of an item
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_PEEK,
    OP_FREE,
    OP_MARK_USED,
    OP_MARK_MOD,
    OP_ADD_REF,
    OP_RANGE,   // block id past the store
    OP_NOP      // unknown command
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [RES_W-1:0] result_block;
    logic [ST_W-1:0]  status;
    logic [RES_W-1:0] total_blocks;
    logic [RES_W-1:0] free_count;
  } rsp_t;

  typedef struct packed {
    op_t              op;
    logic [BLK_W-1:0] blk;
  } qent_t;

endpackage

### design/balloc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module balloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/balloc_front.sv
// Front end: accepts commands, classifies them and holds them in a two-entry queue.
// Depends on balloc_pkg.
module balloc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  balloc_pkg::req_t      req,
  input  logic                  clearing,
  input  logic                  pop,
  output logic                  head_valid,
  output balloc_pkg::qent_t     head
);
  import balloc_pkg::*;

  qent_t      q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push;
  logic       beyond;
  op_t        op;

  assign busy       = (cnt == 2'd2) || clearing;
  assign push       = start && !busy;
  assign head_valid = (cnt != 2'd0);
  assign head       = q[rp];
  assign beyond     = 32'(req.block_number) >= MAX_BLOCKS;

  always_comb begin
    case (req.command)
      CMD_ALLOCATE:      op = OP_ALLOC;
      CMD_PEEK:          op = OP_PEEK;
      CMD_FREE:          op = OP_FREE;
      CMD_MARK_USED:     op = OP_MARK_USED;
      CMD_MARK_MODIFIED: op = OP_MARK_MOD;
      CMD_ADD_REF:       op = OP_ADD_REF;
      default:           op = OP_NOP;
    endcase
    if (beyond && (op == OP_FREE || op == OP_MARK_USED || op == OP_MARK_MOD ||
                   op == OP_ADD_REF)) begin
      op = OP_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        q[wp] <= '{op: op, blk: req.block_number};
        wp    <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

### design/balloc_back.sv
// Back end: owns the free bitmap, per-block entries and counters; executes items.
// Depends on balloc_pkg and balloc_ram.
module balloc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  balloc_pkg::qent_t     head,
  output logic                  pop,
  output logic                  clearing,
  output logic                  done,
  output balloc_pkg::rsp_t      rsp
);
  import balloc_pkg::*;

  localparam int WW  = (MAX_BLOCKS < 64) ? MAX_BLOCKS : 64;
  localparam int NW  = MAX_BLOCKS / WW;
  localparam int FAW = (NW > 1) ? $clog2(NW) : 1;
  localparam int OW  = $clog2(WW);
  localparam int LA  = $clog2(MAX_BLOCKS);
  localparam int BW  = LA + 1;
  localparam int EW  = 34;

  typedef struct packed {
    logic [31:0] uses;
    logic        nf;
    logic        modf;
  } ent_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD, S_FIND, S_EXEC, S_BRD, S_BWR, S_GRD, S_GWR, S_RESP
  } state_t;

  state_t          state;
  op_t             op;
  logic [BW-1:0]   b, hw, ft, res_blk;
  logic [ST_W-1:0] res_st;
  logic [FAW-1:0]  fa, gw, endw;
  logic [LA-1:0]   ba, clr;
  logic [NW-1:0]   sum;

  logic            f_we, b_we;
  logic [FAW-1:0]  f_wa;
  logic [LA-1:0]   b_wa;
  logic [WW-1:0]   f_wd, w, gmask, bitm;
  logic [EW-1:0]   b_rd;
  ent_t            e, b_wd;
  logic [ST_W-1:0] st_x;
  logic            ft_up, ft_dn, fbit;
  logic [31:0]     inc, dec;
  logic [OW-1:0]   foff;
  logic [FAW-1:0]  sidx;
  logic [BW-1:0]   gidx, bm1;

  assign e        = ent_t'(b_rd);
  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && head_valid;
  assign bitm     = WW'(1) << b[OW-1:0];
  assign fbit     = |(w & bitm);
  assign bm1      = b - BW'(1);

  balloc_ram #(.WIDTH(WW), .DEPTH(NW)) u_fmap (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(fa), .rdata(w)
  );

  balloc_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ent (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(ba), .rdata(b_rd)
  );

  // lowest nonempty word and lowest free bit in the fetched word
  always_comb begin
    sidx = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (sum[i]) sidx = FAW'(i);
    end
    foff = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (w[i]) foff = OW'(i);
    end
    gidx = '0;
    for (int i = 0; i < WW; i++) begin
      gidx     = BW'({gw, OW'(i)});
      gmask[i] = (gidx >= hw) && (gidx < b);
    end
  end

  always_comb begin
    inc   = (e.uses == 32'd0) ? 32'd2 : ((e.uses == UC_MAX) ? e.uses : e.uses + 32'd1);
    dec   = e.uses - 32'd1;
    f_we  = 1'b0;
    f_wa  = fa;
    f_wd  = w;
    b_we  = 1'b0;
    b_wa  = ba;
    b_wd  = e;
    st_x  = ST_OK;
    ft_up = 1'b0;
    ft_dn = 1'b0;
    case (state)
      S_CLEAR: begin
        f_we = 1'b1;
        f_wa = clr[FAW-1:0];
        f_wd = '0;
        b_we = 1'b1;
        b_wa = clr;
        b_wd = '0;
      end
      S_FIND: begin
        if (op == OP_ALLOC) begin
          f_we = 1'b1;
          f_wd = w & ~(WW'(1) << foff);
        end
      end
      S_BWR: begin
        b_we    = 1'b1;
        b_wd.nf = 1'b0;
      end
      S_GWR: begin
        f_we = 1'b1;
        f_wd = w | gmask;
      end
      S_EXEC: begin
        case (op)
          OP_FREE: begin
            if (fbit) begin
              st_x = ST_ALREADY_FREE;
            end else begin
              f_we    = 1'b1;
              f_wd    = w | bitm;
              b_we    = 1'b1;
              b_wd    = '{uses: 32'd0, nf: 1'b1, modf: e.modf};
              ft_up   = 1'b1;
            end
          end
          OP_MARK_USED, OP_ADD_REF: begin
            if (fbit && op == OP_MARK_USED) begin
              f_we    = 1'b1;
              f_wd    = w & ~bitm;
              b_we    = 1'b1;
              b_wd.nf = 1'b0;
              ft_dn   = 1'b1;
            end else if (fbit) begin
              st_x = ST_ALREADY_FREE;
            end else begin
              b_we      = 1'b1;
              b_wd.uses = inc;
            end
          end
          OP_MARK_MOD: begin
            if (e.uses != 32'd0) begin
              b_we      = 1'b1;
              b_wd.uses = (dec <= 32'd1) ? 32'd0 : dec;
            end else if (fbit) begin
              st_x = ST_ALREADY_FREE;
            end else begin
              b_we      = 1'b1;
              b_wd.modf = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      hw    <= '0;
      ft    <= '0;
      sum   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (f_we && state != S_CLEAR) begin
        sum[f_wa] <= |f_wd;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + LA'(1);
          if (clr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (head_valid) begin
            op    <= head.op;
            b     <= BW'(head.blk);
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_blk <= '0;
          res_st  <= ST_OK;
          state   <= S_RESP;
          case (op)
            OP_ALLOC, OP_PEEK: begin
              if (|sum) begin
                fa    <= sidx;
                state <= S_RD;
              end else if (hw < BW'(MAX_BLOCKS)) begin
                res_blk <= hw;
                if (op == OP_ALLOC) hw <= hw + BW'(1);
              end else begin
                res_blk <= hw;
                res_st  <= ST_FULL;
              end
            end
            OP_FREE, OP_MARK_MOD, OP_ADD_REF: begin
              if (b >= hw) begin
                res_st <= ST_RANGE;
              end else begin
                fa    <= b[OW +: FAW];
                ba    <= b[LA-1:0];
                state <= S_RD;
              end
            end
            OP_MARK_USED: begin
              if (b < hw) begin
                fa    <= b[OW +: FAW];
                ba    <= b[LA-1:0];
                state <= S_RD;
              end else if (b == hw) begin
                hw <= b + BW'(1);
              end else begin
                // skipped blocks join the free set, one bitmap word at a time
                fa    <= hw[OW +: FAW];
                gw    <= hw[OW +: FAW];
                endw  <= bm1[OW +: FAW];
                state <= S_GRD;
              end
            end
            OP_RANGE: res_st <= ST_RANGE;
            default: ;
          endcase
        end
        S_RD: begin
          state <= (op == OP_ALLOC || op == OP_PEEK) ? S_FIND : S_EXEC;
        end
        S_FIND: begin
          res_blk <= BW'({fa, foff});
          if (op == OP_ALLOC) begin
            ft    <= ft - BW'(1);
            ba    <= LA'({fa, foff});
            state <= S_BRD;
          end else begin
            state <= S_RESP;
          end
        end
        S_BRD: state <= S_BWR;
        S_BWR: state <= S_RESP;
        S_GRD: state <= S_GWR;
        S_GWR: begin
          if (gw == endw) begin
            ft    <= ft + b - hw;
            hw    <= b + BW'(1);
            state <= S_RESP;
          end else begin
            gw    <= gw + FAW'(1);
            fa    <= gw + FAW'(1);
            state <= S_GRD;
          end
        end
        S_EXEC: begin
          res_st <= st_x;
          ft     <= ft + BW'(ft_up) - BW'(ft_dn);
          state  <= S_RESP;
        end
        S_RESP: begin
          done  <= 1'b1;
          rsp   <= '{result_block: RES_W'(res_blk), status: res_st,
                     total_blocks: RES_W'(hw), free_count: RES_W'(ft)};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/block_allocator_refcount.sv
// A taken command waits in the front queue; the back end goes S_IDLE, S_DECODE, then
// S_RESP if settled without a memory read, else via S_RD, S_EXEC for free/mark/add
// reference, S_RD, S_FIND for peek, S_RD, S_FIND, S_BRD, S_BWR for allocate from the
// free set; mark used past the high-water mark goes via S_GRD, S_GWR per word. One item
// runs at a time, two more wait in the front queue, and results never stall since the
// receiver cannot hold them off. After reset, busy is high through a clearing pass.
module block_allocator_refcount (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  balloc_pkg::req_t  req,
  output logic              done,
  output balloc_pkg::rsp_t  rsp
);
  import balloc_pkg::*;

  qent_t head;
  logic  head_valid, pop, clearing;

  balloc_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .clearing(clearing), .pop(pop), .head_valid(head_valid), .head(head)
  );

  balloc_back u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head), .pop(pop),
    .clearing(clearing), .done(done), .rsp(rsp)
  );

endmodule

### design/balloc_chk.sv
// Port-level checks for the block allocator, bound to the top level.
// Depends on balloc_pkg.
module balloc_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input balloc_pkg::req_t  req,
  input logic              done,
  input balloc_pkg::rsp_t  rsp
);
  import balloc_pkg::*;

  // clearing pass holds off commands right after reset
  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results on consecutive cycles");

  a_full_total: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> rsp.total_blocks == RES_W'(MAX_BLOCKS))
    else $error("store full reported below capacity");

  a_already_free_blk: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_ALREADY_FREE) |-> rsp.result_block == '0)
    else $error("nonzero block on already-free status");

  a_req_known: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !$isunknown(req))
    else $error("unknown command fields on an accepted item");

endmodule

bind block_allocator_refcount balloc_chk u_balloc_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp)
);

### verif/tb.sv
// Testbench for block_allocator_refcount: directed and random commands with
// an in-bench allocator predictor. Depends on balloc_pkg and the design top.
module tb;
  import balloc_pkg::*;

  localparam int NBLK = 4096;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_B = 3'd7;
  localparam logic [BLK_W-1:0] DRAIN_BLK     = 12'hFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req = '0;
  rsp_t rsp;

  block_allocator_refcount u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // allocator state mirror
  bit          fr_map [NBLK];
  bit          nf_map [NBLK];
  bit          mod_map [NBLK];
  logic [31:0] refs [NBLK];
  int unsigned hw;
  int unsigned nfree;

  req_t pending_cmds[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  bit   stim_done = 0;

  function automatic int unsigned lowest_free();
    for (int i = 0; i < hw; i++) if (fr_map[i]) return i;
    return NBLK;
  endfunction

  function automatic logic [ST_W-1:0] add_ref(int unsigned b);
    if (b >= hw) return ST_RANGE;
    if (fr_map[b]) return ST_ALREADY_FREE;
    if (refs[b] == 0) refs[b] = 2;
    else if (refs[b] != UC_MAX) refs[b]++;
    return ST_OK;
  endfunction

  function automatic rsp_t predict_alloc(req_t r);
    int unsigned b, f;
    rsp_t o;
    b = r.block_number;
    o = '0;
    o.status = ST_OK;
    case (r.command)
      CMD_ALLOCATE: begin
        f = lowest_free();
        if (f < NBLK) begin
          fr_map[f] = 0; nf_map[f] = 0; nfree--; o.result_block = RES_W'(f);
        end else if (hw < NBLK) begin
          o.result_block = RES_W'(hw); hw++;
        end else begin
          o.result_block = RES_W'(NBLK); o.status = ST_FULL;
        end
      end
      CMD_PEEK: begin
        f = lowest_free();
        if (f < NBLK) o.result_block = RES_W'(f);
        else begin
          o.result_block = RES_W'(hw);
          if (hw >= NBLK) o.status = ST_FULL;
        end
      end
      CMD_FREE: begin
        if (b >= hw) o.status = ST_RANGE;
        else if (fr_map[b]) o.status = ST_ALREADY_FREE;
        else begin
          refs[b] = 0; fr_map[b] = 1; nf_map[b] = 1; nfree++;
        end
      end
      CMD_MARK_USED: begin
        if (b >= hw) begin
          while (hw < b) begin
            fr_map[hw] = 1; nfree++; hw++;
          end
          hw = b + 1;
        end else if (fr_map[b]) begin
          fr_map[b] = 0; nf_map[b] = 0; nfree--;
        end else o.status = add_ref(b);
      end
      CMD_MARK_MODIFIED: begin
        if (b >= hw) o.status = ST_RANGE;
        else if (refs[b] != 0) begin
          refs[b]--;
          if (refs[b] <= 1) refs[b] = 0;
        end else if (fr_map[b]) o.status = ST_ALREADY_FREE;
        else mod_map[b] = 1;
      end
      CMD_ADD_REF: o.status = add_ref(b);
      default: ;
    endcase
    o.total_blocks = RES_W'(hw);
    o.free_count = RES_W'(nfree);
    return o;
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // set at each rising edge that takes an item
  bit took = 0;

  // driver
  int unsigned idle_cnt = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !took) begin
        // hold until accepted
      end else if (idle_cnt != 0) begin
        idle_cnt <= idle_cnt - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        if (pending_cmds[0].command == CMD_UNKNOWN_B && pending_cmds[0].block_number == DRAIN_BLK
            && expected_rsps.size() != 0) begin
          // drain marker: wait for every expected result
          start <= 1'b0;
        end else begin
          req <= pending_cmds.pop_front();
          start <= 1'b1;
          idle_cnt <= gap_len();
        end
      end else begin
        start <= 1'b0;
        if (pending_cmds.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // acceptance tracking at rising edge
  always @(posedge clk) begin
    took = 0;
    if (!rst && start && !busy) begin
      expected_rsps.insert(expected_rsps.size(), predict_alloc(req));
      took = 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $error("result with none expected: %p", rsp);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (rsp.result_block !== e.result_block) begin
          $error("result_block exp %0d got %0d", e.result_block, rsp.result_block); errors++;
        end
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status); errors++;
        end
        if (rsp.total_blocks !== e.total_blocks) begin
          $error("total_blocks exp %0d got %0d", e.total_blocks, rsp.total_blocks); errors++;
        end
        if (rsp.free_count !== e.free_count) begin
          $error("free_count exp %0d got %0d", e.free_count, rsp.free_count); errors++;
        end
      end
    end
  end

  task automatic add_cmd(logic [CMD_W-1:0] c, logic [BLK_W-1:0] b);
    req_t r;
    r.command = c;
    r.block_number = b;
    pending_cmds.insert(pending_cmds.size(), r);
  endtask

  // pick a block id mostly in 0..span, now and then any id
  function automatic logic [BLK_W-1:0] pick_blk(int unsigned span);
    if ($urandom_range(0, 15) == 0) return BLK_W'($urandom());
    return BLK_W'($urandom_range(0, span));
  endfunction

  initial begin
    int unsigned span;
    logic [CMD_W-1:0] c;
    foreach (refs[i]) refs[i] = '0;
    // directed
    add_cmd(CMD_PEEK, '0);
    add_cmd(CMD_FREE, '0);
    add_cmd(CMD_ADD_REF, '0);
    add_cmd(CMD_MARK_MODIFIED, '0);
    add_cmd(CMD_ALLOCATE, '0);
    add_cmd(CMD_ALLOCATE, '0);
    add_cmd(CMD_MARK_USED, 12'd130);
    add_cmd(CMD_ALLOCATE, '0);
    add_cmd(CMD_FREE, 12'd0);
    add_cmd(CMD_FREE, 12'd0);
    add_cmd(CMD_ADD_REF, 12'd1);
    add_cmd(CMD_ADD_REF, 12'd1);
    add_cmd(CMD_MARK_MODIFIED, 12'd1);
    add_cmd(CMD_MARK_MODIFIED, 12'd1);
    add_cmd(CMD_MARK_MODIFIED, 12'd1);
    add_cmd(CMD_MARK_USED, 12'd1);
    add_cmd(CMD_MARK_USED, 12'd5);
    add_cmd(CMD_FREE, 12'd200);
    add_cmd(CMD_UNKNOWN_A, 12'hABC);
    add_cmd(CMD_UNKNOWN_B, 12'h555);
    add_cmd(CMD_MARK_USED, 12'd4095);
    add_cmd(CMD_ALLOCATE, '0);
    add_cmd(CMD_UNKNOWN_B, DRAIN_BLK);   // drain point
    // random: low blocks in the first half, then the full range; allocate-heavy mix
    for (int i = 0; i < 1000; i++) begin
      span = (i < 500) ? 300 : 4095;
      case ($urandom_range(0, 9))
        0, 1, 2: c = CMD_ALLOCATE;
        3: c = CMD_PEEK;
        4, 5: c = CMD_FREE;
        6: c = CMD_MARK_USED;
        7: c = CMD_MARK_MODIFIED;
        8: c = CMD_ADD_REF;
        default: c = CMD_W'($urandom_range(0, 7));
      endcase
      if (c == CMD_UNKNOWN_B) c = CMD_UNKNOWN_A;
      add_cmd(c, pick_blk(span));
      if (i == 500) add_cmd(CMD_UNKNOWN_B, DRAIN_BLK);
    end
    // closing run of allocate and peek with the mark at the top of the store
    add_cmd(CMD_ALLOCATE, '0);
    add_cmd(CMD_PEEK, '0);
    for (int i = 0; i < 40; i++) add_cmd(CMD_ALLOCATE, '0);
    add_cmd(CMD_ALLOCATE, '0);
    add_cmd(CMD_PEEK, '0);
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (stim_done && expected_rsps.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("block_allocator_refcount: match");
    else $display("block_allocator_refcount: mismatch");
    $finish;
  end

  initial begin
    #20000000;
    $display("block_allocator_refcount: mismatch");
    $finish;
  end

endmodule
